>>> hdl/pfu_pkg.sv
package pfu_pkg;

    localparam int MAX_TARGETS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic        PUSH_EN_RST   = 1'b0;
    localparam logic [30:0] GMUL_RST      = 31'd65536;
    localparam logic [30:0] DEADZONE_RST  = 31'd0;
    localparam logic        MASS_ON_RST   = 1'b0;
    localparam logic [30:0] RAD2_RST      = 31'd147456;
    localparam logic [15:0] STALE_RST     = 16'd250;

    localparam logic [30:0] MREF_MIN      = 31'd655;
    localparam logic [30:0] MREF_DEFAULT  = 31'd26214;
    localparam logic [16:0] SCALE_LO      = 17'd3277;
    localparam logic [16:0] SCALE_HI      = 17'd98304;
    localparam logic [16:0] SCALE_ONE     = 17'd65536;

    // numerators are left aligned in 64 bits; steps = significant bits
    localparam logic [6:0]  STEPS_SCALE   = 7'd49;
    localparam logic [6:0]  STEPS_CLAMP   = 7'd63;
    localparam logic [6:0]  STEPS_COMP    = 7'd62;
    localparam logic [6:0]  STEPS_SQRT    = 7'd32;
    localparam logic [63:0] SCALE_NUM     = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OPC_POS    = 3'd0,
        OPC_DISP   = 3'd1,
        OPC_TUNE   = 3'd2,
        OPC_COMMIT = 3'd3,
        OPC_QUERY  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_PUSH_EN = 3'd0,
        CFG_GMUL    = 3'd1,
        CFG_DZ      = 3'd2,
        CFG_MASS_ON = 3'd3,
        CFG_RAD2    = 3'd4,
        CFG_STALE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         slot;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [30:0]        scalar_a;
        logic [30:0]        scalar_b;
        logic [30:0]        scalar_c;
        logic               body_dynamic;
        logic [31:0]        now_ms;
    } t_req_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               force_applied;
        logic [4:0]         matched_target;
        logic [63:0]        applied_total;
    } t_rsp_item;

    typedef enum logic [1:0] {
        ITER_DIV,
        ITER_SQRT
    } t_iter_mode;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TAKE,
        OP_READ,
        OP_SQ,
        OP_NEXT,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_SCALE,
        OP_ELO,
        OP_EHI,
        OP_ESUM,
        OP_LEN,
        OP_LCHK,
        OP_CLAMP,
        OP_COMP,
        OP_CMUL,
        OP_CSAT,
        OP_HIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic drop;
        logic dynamic;
        logic far;
        logic small_disp;
        logic t_last;
        logic sq_last;
        logic mass_scale;
        logic len_zero;
        logic clamp;
        logic k_last;
        logic iter_done;
    } t_dp_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_SQ,
        S_TEST,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SDIV,
        S_ELO,
        S_EHI,
        S_ESUM,
        S_SQRT,
        S_LCHK,
        S_CDIV,
        S_COMP,
        S_QDIV,
        S_CMUL,
        S_CSAT,
        S_HIT,
        S_OUT
    } t_ctrl_state;

endpackage

>>> hdl/pfu_chan_if.sv
interface pfu_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/proximity_matched_clamped_push_force_unit.sv
// Push force unit for a double-banked table of proximity targets.
// i_req carries one beat per item: writes of position, displacement or
// tuning fill the shadow bank, a commit flips banks and stamps the time,
// and a body query asks for a force. Writes and commits return nothing.
// A query dropped for disable, empty table or age returns nothing; any
// other query returns one beat on o_rsp.
// A query scans the targets in order up to the first match; a matched
// target then takes a mass scale divide when enabled, a square root for
// the displacement length and a clamp divide, then per component a
// multiply, after a further divide when the force is clamped. The
// bit-serial divide and square-root unit does this work; one query is worked at a time.
// The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one register
// per cycle; user must use it only while the unit is idle, not enforced.
// Reset returns config to defaults, selects bank 0 with no targets and
// clears the applied counter; table contents are undefined until written.
// While o_rsp is stalled the result beat holds and i_req is not ready.
module proximity_matched_clamped_push_force_unit #(
    parameter int MAX_TARGETS = pfu_pkg::MAX_TARGETS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pfu_chan_if.sink                          i_req,
    pfu_chan_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pfu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_req_item  req_item;
    t_rsp_item  rsp_item;
    logic       in_ready;
    logic       out_valid;

    assign req_item    = i_req.data;
    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp_item;

    pfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pfu_dp #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_req      (req_item),
        .o_rsp      (rsp_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

>>> hdl/pfu_iter.sv
module pfu_iter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pfu_pkg::t_iter_mode  i_mode,
    input  logic [63:0]          i_num,
    input  logic [63:0]          i_den,
    input  logic [6:0]           i_steps,
    output logic [63:0]          o_q,
    output logic                 o_done
);
    import pfu_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [6:0]        r_cnt;
    t_iter_mode        r_mode;
    logic [63:0]       r_num;
    logic [63:0]       r_den;
    logic [63:0]       r_rem;
    logic [63:0]       r_q;

    logic [65:0]       rem_sh;
    logic [65:0]       sub;
    logic [65:0]       diff;
    logic              ge;
    logic [63:0]       n_rem;
    logic [63:0]       n_num;
    logic [63:0]       n_q;

    // restoring divide one bit a step, square root one root bit a step
    always_comb begin
        if (r_mode == ITER_DIV) begin
            rem_sh = {1'b0, r_rem, r_num[63]};
            sub    = {2'b00, r_den};
            n_num  = {r_num[62:0], 1'b0};
        end else begin
            rem_sh = {r_rem, r_num[63:62]};
            sub    = {r_q, 2'b01};
            n_num  = {r_num[61:0], 2'b00};
        end
        ge    = (rem_sh >= sub);
        diff  = rem_sh - sub;
        n_rem = ge ? diff[63:0] : rem_sh[63:0];
        n_q   = {r_q[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= ITER_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_mode <= i_mode;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("iterative unit restarted while busy");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while still iterating");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule

>>> hdl/pfu_dp.sv
module pfu_dp #(
    parameter int MAX_TARGETS = pfu_pkg::MAX_TARGETS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfu_pkg::t_dp_cmd                  i_cmd,
    output pfu_pkg::t_dp_status               o_status,
    input  pfu_pkg::t_req_item                i_req,
    output pfu_pkg::t_rsp_item                o_rsp,
    input  logic                              i_cfg_we,
    input  logic [pfu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pfu_pkg::*;

    localparam int TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CW    = $clog2(MAX_TARGETS + 1);
    localparam int DEPTH = 2 ** (TW + 1);

    // configuration
    logic        r_push_en;
    logic [30:0] r_gmul;
    logic [30:0] r_dz;
    logic        r_mass_on;
    logic [30:0] r_rad2;
    logic [15:0] r_stale;
    logic [63:0] r_dz2;

    // table control
    logic          r_bank;
    logic [CW-1:0] r_count;
    logic [31:0]   r_stamp;
    logic [63:0]   r_total;

    // banked tables, row = {z, y, x} or {ref mass, max force, gain}
    logic [95:0] mem_pos  [DEPTH];
    logic [95:0] mem_disp [DEPTH];
    logic [92:0] mem_tune [DEPTH];
    logic [95:0] r_rd_pos;
    logic [95:0] r_rd_disp;
    logic [92:0] r_rd_tune;

    // query working registers
    logic [95:0]   r_body;
    logic [30:0]   r_sa;
    logic [CW-1:0] r_t;
    logic [1:0]    r_k;
    logic [63:0]   r_d2;
    logic [63:0]   r_m2;
    logic [63:0]   r_pa;
    logic [63:0]   r_pb;
    logic [63:0]   r_den;
    logic [46:0]   r_eff;
    logic [46:0]   r_emax;
    logic [16:0]   r_scale;
    logic [63:0]   r_lo_e;
    logic [63:0]   r_lo_m;
    logic [31:0]   r_len;
    logic          r_clamp;
    logic [31:0]   r_force [3];
    logic          r_applied;
    logic [4:0]    r_tgt;

    logic [31:0] ma_a, ma_b, mb_a, mb_b;
    logic [63:0] prod_a, prod_b;
    logic [61:0] prod_dz;

    logic [TW:0]   wr_addr;
    logic [TW:0]   rd_addr;
    logic          slot_ok;
    logic [CW-1:0] commit_cnt;
    logic          take;

    logic signed [31:0] body_c, pos_c, disp_c;
    logic [32:0]        diff_c;
    logic [32:0]        disp_neg;
    logic [31:0]        diff_abs;
    logic [31:0]        disp_abs;
    logic [30:0]        gain, maxf, mref_raw, mref;
    logic [64:0]        d2_sum;
    logic [95:0]        sum_e, sum_m;
    logic [63:0]        mag;
    logic [31:0]        out_val;
    logic [31:0]        age;
    logic [CW:0]        t_next;
    logic [6:0]         t_wide;

    logic        iter_start;
    t_iter_mode  iter_mode;
    logic [63:0] iter_num;
    logic [63:0] iter_den;
    logic [6:0]  iter_steps;
    logic [63:0] iter_q;
    logic        iter_done;

    assign take    = (i_cmd.op == OP_TAKE);
    assign slot_ok = ({1'b0, i_req.slot} < 7'(MAX_TARGETS));
    assign wr_addr = {~r_bank, i_req.slot[TW-1:0]};
    assign rd_addr = {r_bank, r_t[TW-1:0]};
    assign commit_cnt = ({1'b0, i_req.slot} > 7'(MAX_TARGETS)) ? CW'(MAX_TARGETS)
                                                               : CW'(i_req.slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_en <= PUSH_EN_RST;
            r_gmul    <= GMUL_RST;
            r_dz      <= DEADZONE_RST;
            r_mass_on <= MASS_ON_RST;
            r_rad2    <= RAD2_RST;
            r_stale   <= STALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PUSH_EN: r_push_en <= i_cfg_data[0];
                CFG_GMUL:    r_gmul    <= i_cfg_data;
                CFG_DZ:      r_dz      <= i_cfg_data;
                CFG_MASS_ON: r_mass_on <= i_cfg_data[0];
                CFG_RAD2:    r_rad2    <= i_cfg_data;
                CFG_STALE:   r_stale   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign prod_dz = {31'b0, r_dz} * {31'b0, r_dz};

    always_ff @(posedge i_clk) begin
        r_dz2 <= {2'b00, prod_dz};
    end

    // table writes go to the shadow bank
    always_ff @(posedge i_clk) begin
        if (take && slot_ok) begin
            if (i_req.opcode == OPC_POS)
                mem_pos[wr_addr] <= {i_req.vec_z, i_req.vec_y, i_req.vec_x};
            if (i_req.opcode == OPC_DISP)
                mem_disp[wr_addr] <= {i_req.vec_z, i_req.vec_y, i_req.vec_x};
            if (i_req.opcode == OPC_TUNE)
                mem_tune[wr_addr] <= {i_req.scalar_c, i_req.scalar_b, i_req.scalar_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_READ) begin
            r_rd_pos  <= mem_pos[rd_addr];
            r_rd_disp <= mem_disp[rd_addr];
            r_rd_tune <= mem_tune[rd_addr];
        end
    end

    always_comb begin
        case (r_k)
            2'd0: begin
                body_c = r_body[31:0];
                pos_c  = r_rd_pos[31:0];
                disp_c = r_rd_disp[31:0];
            end
            2'd1: begin
                body_c = r_body[63:32];
                pos_c  = r_rd_pos[63:32];
                disp_c = r_rd_disp[63:32];
            end
            default: begin
                body_c = r_body[95:64];
                pos_c  = r_rd_pos[95:64];
                disp_c = r_rd_disp[95:64];
            end
        endcase
        diff_c   = {body_c[31], body_c} - {pos_c[31], pos_c};
        diff_abs = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
        disp_neg = -{disp_c[31], disp_c};
        disp_abs = disp_c[31] ? disp_neg[31:0] : disp_c;
        gain     = r_rd_tune[30:0];
        maxf     = r_rd_tune[61:31];
        mref_raw = r_rd_tune[92:62];
        mref     = (mref_raw <= MREF_MIN) ? MREF_DEFAULT : mref_raw;
    end

    always_comb begin
        ma_a = '0;
        ma_b = '0;
        mb_a = '0;
        mb_b = '0;
        case (i_cmd.op)
            OP_SQ: begin
                ma_a = diff_abs;
                ma_b = diff_abs;
                mb_a = disp_abs;
                mb_b = disp_abs;
            end
            OP_MUL1: begin
                ma_a = {1'b0, r_sa};
                ma_b = {1'b0, mref};
                mb_a = {1'b0, gain};
                mb_b = {1'b0, r_gmul};
            end
            OP_MUL2: begin
                ma_a = {1'b0, maxf};
                ma_b = {1'b0, r_gmul};
            end
            OP_ELO: begin
                ma_a = r_eff[31:0];
                ma_b = {15'b0, r_scale};
                mb_a = r_emax[31:0];
                mb_b = {15'b0, r_scale};
            end
            OP_EHI: begin
                ma_a = {17'b0, r_eff[46:32]};
                ma_b = {15'b0, r_scale};
                mb_a = {17'b0, r_emax[46:32]};
                mb_b = {15'b0, r_scale};
            end
            OP_CMUL: begin
                if (r_clamp) begin
                    ma_a = iter_q[31:0];
                    ma_b = r_emax[31:0];
                    mb_a = iter_q[31:0];
                    mb_b = {17'b0, r_emax[46:32]};
                end else begin
                    ma_a = disp_abs;
                    ma_b = r_eff[31:0];
                    mb_a = disp_abs;
                    mb_b = {17'b0, r_eff[46:32]};
                end
            end
            default: ;
        endcase
    end

    assign prod_a = {32'b0, ma_a} * {32'b0, ma_b};
    assign prod_b = {32'b0, mb_a} * {32'b0, mb_b};

    always_ff @(posedge i_clk) begin
        r_pa <= prod_a;
        r_pb <= prod_b;
    end

    always_comb begin
        d2_sum = {1'b0, r_d2} + {1'b0, r_pa};
        sum_e  = {r_pa, 32'b0} + {32'b0, r_lo_e};
        sum_m  = {r_pb, 32'b0} + {32'b0, r_lo_m};
        if (r_clamp)
            mag = {r_pb[61:0], 2'b00} + {30'b0, r_pa[63:30]};
        else
            mag = {r_pb[47:0], 16'b0} + {16'b0, r_pa[63:16]};
        if (disp_c[31]) begin
            out_val = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
        end else begin
            out_val = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        age    = i_req.now_ms - r_stamp;
        t_next = {1'b0, r_t} + 1'b1;
        t_wide = 7'(r_t);
    end

    always_comb begin
        iter_start = 1'b0;
        iter_mode  = ITER_DIV;
        iter_num   = SCALE_NUM;
        iter_den   = r_den;
        iter_steps = STEPS_SCALE;
        case (i_cmd.op)
            OP_MUL3: iter_start = r_mass_on && (r_sa != '0);
            OP_ESUM: begin
                iter_start = 1'b1;
                iter_mode  = ITER_SQRT;
                iter_num   = r_m2;
                iter_steps = STEPS_SQRT;
            end
            OP_LCHK: begin
                iter_start = (r_len != '0);
                iter_num   = {r_emax, 17'b0};
                iter_den   = {32'b0, r_len};
                iter_steps = STEPS_CLAMP;
            end
            OP_COMP: begin
                iter_start = r_clamp;
                iter_num   = {disp_abs, 32'b0};
                iter_den   = {32'b0, r_len};
                iter_steps = STEPS_COMP;
            end
            default: ;
        endcase
    end

    pfu_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iter_start),
        .i_mode  (iter_mode),
        .i_num   (iter_num),
        .i_den   (iter_den),
        .i_steps (iter_steps),
        .o_q     (iter_q),
        .o_done  (iter_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_stamp <= '0;
            r_total <= '0;
            r_t     <= '0;
            r_k     <= '0;
        end else begin
            case (i_cmd.op)
                OP_TAKE: begin
                    if (i_req.opcode == OPC_COMMIT) begin
                        r_bank  <= ~r_bank;
                        r_count <= commit_cnt;
                        r_stamp <= i_req.now_ms;
                    end
                    r_t <= '0;
                end
                OP_READ: r_k <= '0;
                OP_SQ:   r_k <= r_k + 2'd1;
                OP_NEXT: r_t <= r_t + 1'b1;
                OP_LEN:  r_k <= '0;
                OP_CSAT: r_k <= r_k + 2'd1;
                OP_HIT:  r_total <= r_total + 64'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TAKE: begin
                r_body    <= {i_req.vec_z, i_req.vec_y, i_req.vec_x};
                r_sa      <= i_req.scalar_a;
                r_force   <= '{default: '0};
                r_applied <= 1'b0;
                r_tgt     <= '0;
            end
            OP_READ: begin
                r_d2 <= '0;
                r_m2 <= '0;
            end
            OP_SQ: begin
                if (r_k != 2'd0) begin
                    r_d2 <= d2_sum[64] ? '1 : d2_sum[63:0];
                    r_m2 <= r_m2 + r_pb;
                end
            end
            OP_MUL2: begin
                r_den <= r_pa;
                r_eff <= r_pb[62:16];
            end
            OP_MUL3: begin
                r_emax  <= r_pa[62:16];
                r_scale <= SCALE_ONE;
            end
            OP_SCALE: begin
                if (iter_q > {47'b0, SCALE_HI})
                    r_scale <= SCALE_HI;
                else if (iter_q < {47'b0, SCALE_LO})
                    r_scale <= SCALE_LO;
                else
                    r_scale <= iter_q[16:0];
            end
            OP_EHI: begin
                r_lo_e <= r_pa;
                r_lo_m <= r_pb;
            end
            OP_ESUM: begin
                r_eff  <= sum_e[62:16];
                r_emax <= sum_m[62:16];
            end
            OP_LEN:   r_len   <= iter_q[31:0];
            OP_LCHK:  r_clamp <= 1'b0;
            OP_CLAMP: r_clamp <= ({17'b0, r_eff} > iter_q);
            OP_CSAT:  r_force[r_k] <= out_val;
            OP_HIT: begin
                r_applied <= 1'b1;
                r_tgt     <= t_wide[4:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.is_query   = (i_req.opcode == OPC_QUERY);
        o_status.drop       = !r_push_en || (r_count == '0) || (age > {16'b0, r_stale});
        o_status.dynamic    = i_req.body_dynamic;
        o_status.far        = (r_d2 > {17'b0, r_rad2, 16'b0});
        o_status.small_disp = (r_m2 < r_dz2);
        o_status.t_last     = (t_next >= {1'b0, r_count});
        o_status.sq_last    = (r_k == 2'd3);
        o_status.mass_scale = r_mass_on && (r_sa != '0);
        o_status.len_zero   = (r_len == '0);
        o_status.clamp      = r_clamp;
        o_status.k_last     = (r_k == 2'd2);
        o_status.iter_done  = iter_done;
    end

    assign o_rsp.force_x        = r_force[0];
    assign o_rsp.force_y        = r_force[1];
    assign o_rsp.force_z        = r_force[2];
    assign o_rsp.force_applied  = r_applied;
    assign o_rsp.matched_target = r_tgt;
    assign o_rsp.applied_total  = r_total;

endmodule

>>> hdl/pfu_ctrl.sv
module pfu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  pfu_pkg::t_dp_status  i_status,
    output pfu_pkg::t_dp_cmd     o_cmd
);
    import pfu_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_TAKE;
                    if (i_status.is_query && !i_status.drop)
                        n_state = i_status.dynamic ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (i_status.sq_last)
                    n_state = S_TEST;
            end
            S_TEST: begin
                if (i_status.far || i_status.small_disp) begin
                    if (i_status.t_last) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_NEXT;
                        n_state  = S_READ;
                    end
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.op = OP_MUL3;
                n_state  = i_status.mass_scale ? S_SDIV : S_ELO;
            end
            S_SDIV: begin
                if (i_status.iter_done) begin
                    o_cmd.op = OP_SCALE;
                    n_state  = S_ELO;
                end
            end
            S_ELO: begin
                o_cmd.op = OP_ELO;
                n_state  = S_EHI;
            end
            S_EHI: begin
                o_cmd.op = OP_EHI;
                n_state  = S_ESUM;
            end
            S_ESUM: begin
                o_cmd.op = OP_ESUM;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                if (i_status.iter_done) begin
                    o_cmd.op = OP_LEN;
                    n_state  = S_LCHK;
                end
            end
            S_LCHK: begin
                o_cmd.op = OP_LCHK;
                n_state  = i_status.len_zero ? S_COMP : S_CDIV;
            end
            S_CDIV: begin
                if (i_status.iter_done) begin
                    o_cmd.op = OP_CLAMP;
                    n_state  = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.op = OP_COMP;
                n_state  = i_status.clamp ? S_QDIV : S_CMUL;
            end
            S_QDIV: begin
                if (i_status.iter_done)
                    n_state = S_CMUL;
            end
            S_CMUL: begin
                o_cmd.op = OP_CMUL;
                n_state  = S_CSAT;
            end
            S_CSAT: begin
                o_cmd.op = OP_CSAT;
                n_state  = i_status.k_last ? S_HIT : S_COMP;
            end
            S_HIT: begin
                o_cmd.op = OP_HIT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input taken while a result is pending");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.iter_done |-> (r_state == S_SDIV || r_state == S_SQRT ||
                                r_state == S_CDIV || r_state == S_QDIV))
        else $error("iterative result arrived outside a wait state");

    a_hit_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT) |=> (r_state == S_OUT))
        else $error("hit not followed by result");

endmodule

>>> test/proximity_matched_clamped_push_force_unit_tb.sv
module proximity_matched_clamped_push_force_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfu_pkg::*;

    localparam int NT = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 600;

    class push_force_scoreboard;
        logic [31:0] pos[2][NT][3];
        logic [31:0] disp[2][NT][3];
        logic [30:0] tune[2][NT][3];
        bit [2:0]    written[2][NT];
        bit          bank;
        int unsigned count;
        logic [31:0] stamp;
        logic [63:0] applied;

        bit          push_en;
        logic [30:0] gmul;
        logic [30:0] dzone;
        bit          mass_on;
        logic [30:0] rad2;
        logic [15:0] stale;

        t_rsp_item   expected_forces[$];
        int          errors;
        int          n_results;
        int          n_hits;

        function new();
            bank = 0; count = 0; stamp = '0; applied = '0;
            push_en = PUSH_EN_RST; gmul = GMUL_RST; dzone = DEADZONE_RST;
            mass_on = MASS_ON_RST; rad2 = RAD2_RST; stale = STALE_RST;
            errors = 0; n_results = 0; n_hits = 0;
            foreach (written[b, s]) written[b][s] = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [30:0] v);
            case (idx)
                CFG_PUSH_EN: push_en = v[0];
                CFG_GMUL:    gmul = v;
                CFG_DZ:      dzone = v;
                CFG_MASS_ON: mass_on = v[0];
                CFG_RAD2:    rad2 = v;
                CFG_STALE:   stale = v[15:0];
                default: ;
            endcase
        endfunction

        // slots of the shadow bank that are fully loaded, counted from 0
        function int shadow_prefix();
            int n;
            n = 0;
            while (n < NT && written[!bank][n] == 3'b111) n++;
            return n;
        endfunction

        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] res, b;
            res = '0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [31:0] signed_sat(logic [127:0] mag, bit neg);
            if (neg) begin
                if (mag > 128'h8000_0000) mag = 128'h8000_0000;
                return 32'(-mag[31:0]);
            end
            if (mag > 128'h7FFF_FFFF) mag = 128'h7FFF_FFFF;
            return mag[31:0];
        endfunction

        function void note(t_req_item it);
            bit          sh;
            t_rsp_item   r;
            logic [31:0] v[3];
            logic [63:0] d2, m2, r2, dz2, a, eff, emax, len, scale, mref, q;
            logic [64:0] sum;
            logic [127:0] mag;
            longint      diff;
            longint      dv[3];
            sh = !bank;
            v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
            case (it.opcode)
                OPC_POS, OPC_DISP, OPC_TUNE: begin
                    if (it.slot >= NT) return;
                    for (int c = 0; c < 3; c++) begin
                        if (it.opcode == OPC_POS) pos[sh][it.slot][c] = v[c];
                        if (it.opcode == OPC_DISP) disp[sh][it.slot][c] = v[c];
                    end
                    if (it.opcode == OPC_TUNE) begin
                        tune[sh][it.slot][0] = it.scalar_a;
                        tune[sh][it.slot][1] = it.scalar_b;
                        tune[sh][it.slot][2] = it.scalar_c;
                    end
                    written[sh][it.slot][it.opcode] = 1'b1;
                end
                OPC_COMMIT: begin
                    count = (it.slot > NT) ? NT : it.slot;
                    bank = sh;
                    stamp = it.now_ms;
                end
                OPC_QUERY: begin
                    if (!push_en || count == 0) return;
                    if (32'(it.now_ms - stamp) > {16'd0, stale}) return;
                    r = '0;
                    if (it.body_dynamic) begin
                        r2 = {33'd0, rad2} << 16;
                        dz2 = 64'(dzone) * 64'(dzone);
                        for (int t = 0; t < count; t++) begin
                            d2 = '0; m2 = '0;
                            for (int c = 0; c < 3; c++) begin
                                diff = longint'($signed(v[c])) - longint'($signed(pos[bank][t][c]));
                                a = (diff < 0) ? 64'(-diff) : 64'(diff);
                                sum = 65'(d2) + 65'(a * a);
                                d2 = sum[64] ? '1 : sum[63:0];
                                dv[c] = longint'($signed(disp[bank][t][c]));
                                a = (dv[c] < 0) ? 64'(-dv[c]) : 64'(dv[c]);
                                m2 = m2 + a * a;
                            end
                            if (d2 > r2 || m2 < dz2) continue;
                            scale = 64'd65536;
                            if (mass_on && it.scalar_a != 0) begin
                                mref = 64'(tune[bank][t][2]);
                                if (mref <= 64'(MREF_MIN)) mref = 64'(MREF_DEFAULT);
                                scale = (64'd1 << 48) / (64'(it.scalar_a) * mref);
                                if (scale > 64'(SCALE_HI)) scale = 64'(SCALE_HI);
                                else if (scale < 64'(SCALE_LO)) scale = 64'(SCALE_LO);
                            end
                            eff = (64'(tune[bank][t][0]) * 64'(gmul)) >> 16;
                            eff = (eff * scale) >> 16;
                            emax = (64'(tune[bank][t][1]) * 64'(gmul)) >> 16;
                            emax = (emax * scale) >> 16;
                            len = isqrt(m2);
                            for (int c = 0; c < 3; c++) begin
                                a = (dv[c] < 0) ? 64'(-dv[c]) : 64'(dv[c]);
                                if (len > 0 && eff > (emax << 16) / len) begin
                                    q = (a << 30) / len;
                                    mag = (128'(q) * 128'(emax)) >> 30;
                                end else begin
                                    mag = (128'(a) * 128'(eff)) >> 16;
                                end
                                case (c)
                                    0: r.force_x = signed_sat(mag, dv[c] < 0);
                                    1: r.force_y = signed_sat(mag, dv[c] < 0);
                                    default: r.force_z = signed_sat(mag, dv[c] < 0);
                                endcase
                            end
                            applied = applied + 1;
                            r.force_applied = 1'b1;
                            r.matched_target = 5'(t);
                            break;
                        end
                    end
                    r.applied_total = applied;
                    expected_forces.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] got);
            if (e !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, got);
                errors++;
            end
        endfunction

        function void check(t_rsp_item got);
            t_rsp_item e;
            n_results++;
            if (expected_forces.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %p", $time, got);
                errors++;
                return;
            end
            e = expected_forces.pop_front();
            if (got.force_applied === 1'b1) n_hits++;
            cmp("force_x", 64'(e.force_x), 64'(got.force_x));
            cmp("force_y", 64'(e.force_y), 64'(got.force_y));
            cmp("force_z", 64'(e.force_z), 64'(got.force_z));
            cmp("force_applied", 64'(e.force_applied), 64'(got.force_applied));
            cmp("matched_target", 64'(e.matched_target), 64'(got.matched_target));
            cmp("applied_total", e.applied_total, got.applied_total);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pfu_chan_if #(.t_payload(t_req_item)) req_if ();
    pfu_chan_if #(.t_payload(t_rsp_item)) rsp_if ();

    proximity_matched_clamped_push_force_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    push_force_scoreboard sb = new();

    int unsigned src_idle;
    int unsigned snk_idle;
    int unsigned clk_ms;
    int          n_items;
    int          stall_cycles;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
            if (req_if.valid && req_if.ready) sb.note(req_if.data);
            if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_req_item mk(t_opcode op, logic [5:0] slot,
                                     logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [30:0] a, logic [30:0] b, logic [30:0] c,
                                     bit dyn, logic [31:0] now);
        t_req_item it;
        it.opcode = op; it.slot = slot;
        it.vec_x = x; it.vec_y = y; it.vec_z = z;
        it.scalar_a = a; it.scalar_b = b; it.scalar_c = c;
        it.body_dynamic = dyn; it.now_ms = now;
        return it;
    endfunction

    function automatic logic [30:0] rnd31();
        return 31'($urandom() >> $urandom_range(1, 31));
    endfunction

    function automatic logic [31:0] rnd_signed();
        logic [31:0] v;
        v = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [31:0] rnd_coord();
        if ($urandom_range(9) == 0) return $urandom();
        return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(t_req_item it);
        while ($urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= it;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [30:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic quiesce();
        req_if.valid <= 1'b0;
        while (sb.expected_forces.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(bit en, logic [30:0] gm, logic [30:0] dz, bit mass,
                             logic [30:0] r2, logic [15:0] st);
        quiesce();
        write_reg(CFG_PUSH_EN, 31'(en));
        write_reg(CFG_GMUL, gm);
        write_reg(CFG_DZ, dz);
        write_reg(CFG_MASS_ON, 31'(mass));
        write_reg(CFG_RAD2, r2);
        write_reg(CFG_STALE, 31'(st));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_target(int slot, logic [31:0] p[3], logic [31:0] d[3],
                               logic [30:0] g, logic [30:0] fmax, logic [30:0] mref);
        send(mk(OPC_POS, 6'(slot), p[0], p[1], p[2], rnd31(), rnd31(), rnd31(),
                $urandom_range(1), $urandom()));
        send(mk(OPC_DISP, 6'(slot), d[0], d[1], d[2], rnd31(), rnd31(), rnd31(),
                $urandom_range(1), $urandom()));
        send(mk(OPC_TUNE, 6'(slot), $urandom(), $urandom(), $urandom(), g, fmax, mref,
                $urandom_range(1), $urandom()));
    endtask

    task automatic load_random_target(int slot);
        logic [31:0] p[3];
        logic [31:0] d[3];
        logic [30:0] mref;
        foreach (p[c]) p[c] = rnd_coord();
        foreach (d[c]) d[c] = rnd_signed();
        mref = ($urandom_range(4) == 0) ? 31'($urandom_range(0, 655)) : rnd31();
        load_target(slot, p, d, rnd31(), rnd31(), mref);
    endtask

    task automatic commit(logic [5:0] cnt, logic [31:0] now);
        send(mk(OPC_COMMIT, cnt, $urandom(), $urandom(), $urandom(),
                rnd31(), rnd31(), rnd31(), $urandom_range(1), now));
    endtask

    task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [30:0] inv_mass, bit dyn, logic [31:0] now);
        send(mk(OPC_QUERY, 6'($urandom_range(0, 63)), x, y, z, inv_mass, rnd31(), rnd31(),
                dyn, now));
    endtask

    // load a table into the shadow bank, sometimes leaving a slot half written
    task automatic load_table();
        int n, pre, cnt;
        n = ($urandom_range(9) == 0) ? NT : $urandom_range(1, 6);
        for (int s = 0; s < n; s++) begin
            if ($urandom_range(19) == 0) begin
                send(mk(OPC_POS, 6'(s), rnd_coord(), rnd_coord(), rnd_coord(),
                        rnd31(), rnd31(), rnd31(), 1'b1, $urandom()));
            end else begin
                load_random_target(s);
            end
        end
        pre = sb.shadow_prefix();
        if (pre == NT && $urandom_range(1)) cnt = $urandom_range(NT, 63);
        else if ($urandom_range(3) == 0) cnt = $urandom_range(0, pre);
        else cnt = (n <= pre) ? n : pre;
        commit(6'(cnt), clk_ms);
    endtask

    task automatic send_noise();
        logic [2:0] op;
        op = 3'($urandom_range(0, 7));
        if (op <= 3'(OPC_TUNE)) begin
            send(mk(t_opcode'(op), 6'($urandom_range(NT, 63)), $urandom(), $urandom(),
                    $urandom(), rnd31(), rnd31(), rnd31(), $urandom_range(1), $urandom()));
        end else begin
            send(mk(t_opcode'($urandom_range(5, 7)), 6'($urandom_range(0, 63)), $urandom(),
                    $urandom(), $urandom(), rnd31(), rnd31(), rnd31(), $urandom_range(1),
                    $urandom()));
        end
        n_items--;
    endtask

    task automatic random_query();
        logic [31:0] b[3];
        logic [31:0] now;
        int t, k;
        t = (sb.count > 0) ? $urandom_range(0, sb.count - 1) : 0;
        for (int c = 0; c < 3; c++) begin
            b[c] = sb.pos[sb.bank][t][c];
            if (b[c] === 'x) b[c] = '0;
            case ($urandom_range(3))
                0: ;
                1: b[c] = b[c] + 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
                2: b[c] = b[c] + 32'($urandom_range(0, 1 << 15)) - 32'(1 << 14);
                default: b[c] = $urandom();
            endcase
        end
        k = $urandom_range(99);
        if (k < 8) now = sb.stamp + 32'(sb.stale) + 1 + $urandom_range(0, 100);
        else if (k < 12) now = sb.stamp - $urandom_range(1, 100);
        else if (k < 15) now = sb.stamp + 32'(sb.stale);
        else now = clk_ms;
        query(b[0], b[1], b[2], ($urandom_range(4) == 0) ? 31'd0 : rnd31(),
              ($urandom_range(9) != 0), now);
    endtask

    task automatic random_phase(int n);
        int start;
        start = n_items;
        while (n_items - start < n) begin
            clk_ms += $urandom_range(0, 3);
            case ($urandom_range(19))
                0, 1, 2: load_table();
                3:       send_noise();
                default: random_query();
            endcase
        end
    endtask

    initial begin
        logic [31:0] p[3];
        logic [31:0] d[3];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        src_idle = 0;
        snk_idle = 0;
        clk_ms = 0;
        n_items = 0;
        stall_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table and disabled unit: both queries are dropped
        query(32'd0, 32'd0, 32'd0, 31'd0, 1'b1, 32'd0);
        p = '{32'd0, 32'd0, 32'd0};
        d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
        load_target(0, p, d, 31'h7FFF_FFFF, 31'd65536, 31'd0);
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
        d = '{32'd65536, -32'd65536, 32'd0};
        load_target(1, p, d, 31'd65536, 31'h7FFF_FFFF, 31'd1000000);
        send(mk(OPC_POS, 6'd32, $urandom(), $urandom(), $urandom(), 0, 0, 0, 1'b1, 0));
        send(mk(OPC_DISP, 6'd63, $urandom(), $urandom(), $urandom(), 0, 0, 0, 1'b1, 0));
        send(mk(t_opcode'(3'd5), 6'd1, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 1'b1, 0));
        send(mk(t_opcode'(3'd7), 6'd2, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 0));
        commit(6'd2, 32'd1000);
        query(32'd0, 32'd0, 32'd0, 31'd0, 1'b1, 32'd1000);

        configure(1'b1, GMUL_RST, DEADZONE_RST, 1'b0, RAD2_RST, STALE_RST);
        query(32'd0, 32'd0, 32'd0, 31'd0, 1'b1, 32'd1000);              // clamped
        query(32'd0, 32'd0, 32'd0, 31'd0, 1'b0, 32'd1010);              // static body
        query(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 31'd1, 1'b1, 32'd1250);
        query(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 31'd5, 1'b1, 32'd1100);
        query(32'd0, 32'd0, 32'd0, 31'd0, 1'b1, 32'd1251);              // stale
        p = '{32'd65536, 32'd0, 32'd0};
        d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        load_target(0, p, d, 31'd100, 31'd200, 31'd700);
        commit(6'd1, 32'hFFFF_FFF0);
        query(32'd65536, 32'd0, 32'd0, 31'd0, 1'b1, 32'd5);             // time wrap

        configure(1'b1, 31'h7FFF_FFFF, 31'd0, 1'b1, 31'h7FFF_FFFF, 16'hFFFF);
        query(32'd65536, 32'd0, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'd20);
        query(32'd65536, 32'd0, 32'd0, 31'd1, 1'b1, 32'd20);
        query(32'd65536, 32'd0, 32'd0, 31'd65536, 1'b1, 32'd20);
        clk_ms = 32'd20;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(1'b1, GMUL_RST, DEADZONE_RST, 1'b0, RAD2_RST, STALE_RST);
                1: configure(1'b1, 31'h7FFF_FFFF, 31'($urandom_range(0, 1 << 16)), 1'b1,
                             31'h7FFF_FFFF, 16'hFFFF);
                2: configure(1'b1, 31'd0, 31'd0, 1'b1, 31'd0, 16'd0);
                4: configure(1'b1, rnd31(), 31'h7FFF_FFFF, 1'b0, 31'h7FFF_FFFF, 16'd1000);
                default: configure(1'b1, 31'($urandom_range(0, 1 << 18)),
                                   31'($urandom_range(0, 1 << 17)), $urandom_range(1),
                                   31'($urandom_range(0, 1 << 20)),
                                   16'($urandom_range(1, 1000)));
            endcase
            case (ph / 2)
                0: begin src_idle = 15; snk_idle = 79; end
                1: begin src_idle = 79; snk_idle = 15; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            random_phase(210);
        end

        req_if.valid <= 1'b0;
        while (sb.expected_forces.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d table, commit and query beats over six register settings;",
                 n_items);
        $display("checked %0d result beats, %0d of them with an applied push.",
                 sb.n_results, sb.n_hits);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
